/* src/tmcw_pkg.sv */
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared widths and character codes for the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int MODE_W   = 1;
    localparam int SCREEN_W = 3;
    localparam int BYTE_W   = 8;
    localparam int CADDR_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;

    localparam logic [MODE_W-1:0] MODE_WRITE = 1'b0;
    localparam logic [MODE_W-1:0] MODE_READ  = 1'b1;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [CELL_W-1:0] TEXT_ATTR  = 16'h0700;

    localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'd126;

endpackage

/* src/tmcw_req_if.sv */
// ----------------------------------------------------------------------------
// tmcw_req_if
// Request channel: one write byte or one cell read per transaction.
// ----------------------------------------------------------------------------
interface tmcw_req_if;
    import tmcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SCREEN_W-1:0] screen_index;
    logic [BYTE_W-1:0]   data_byte;
    logic [CADDR_W-1:0]  cell_address;

    modport source (
        output valid, mode, screen_index, data_byte, cell_address,
        input  ready
    );

    modport sink (
        input  valid, mode, screen_index, data_byte, cell_address,
        output ready
    );
endinterface

/* src/tmcw_rsp_if.sv */
// ----------------------------------------------------------------------------
// tmcw_rsp_if
// Response channel: cursor, read cell and scroll flag per transaction.
// ----------------------------------------------------------------------------
interface tmcw_rsp_if;
    import tmcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;

    modport source (
        output valid, cursor_position, cell_value, scrolled,
        input  ready
    );

    modport sink (
        input  valid, cursor_position, cell_value, scrolled,
        output ready
    );
endinterface

/* src/text_mode_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_mode_console_writer_top
// Multi-screen text-mode console: SCREENS screens of COLUMNS x ROWS cells,
// attribute in the high byte and character in the low byte, one cursor each.
// All cells live in one single-port-write RAM; cursors live in flip-flops.
// After reset a clearing pass writes the blank cell 0x0720 to every RAM entry,
// one per cycle; no request is taken until it ends. Each transaction then gets
// one response. A cell read whose address lies past the last cell skips the
// RAM read, and a tab writes one space per cell that it advances. A scroll
// walks the screen through the RAM, one cell per cycle, then blanks the
// bottom row. The next request is accepted while a finished response still
// waits.
// ----------------------------------------------------------------------------
module text_mode_console_writer_top #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int SCREENS   = 5,
    parameter int TAB_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    tmcw_req_if.sink   req,
    tmcw_rsp_if.source rsp
);
    import tmcw_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int TOTAL    = SCREENS * CELLS;
    localparam int AW       = $clog2(TOTAL);
    localparam int OW       = $clog2(CELLS);
    localparam int CW       = $clog2(COLUMNS);
    localparam int TW       = $clog2(TAB_WIDTH);
    localparam int TLW      = $clog2(TAB_WIDTH + 1);
    localparam int SIW      = (SCREENS > 1) ? $clog2(SCREENS) : 1;
    localparam int LAST_ROW = CELLS - COLUMNS;
    localparam int CMT      = COLUMNS % TAB_WIDTH;
    localparam int LAST_PH  = LAST_ROW % TAB_WIDTH;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_RDWAIT = 8'b0000_1000,
        S_TAB    = 8'b0001_0000,
        S_SCROLL = 8'b0010_0000,
        S_BLANK  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]      clr_reg, clr_next;
    logic [OW-1:0]      cnt_reg, cnt_next;
    logic [TLW-1:0]     tab_reg, tab_next;
    logic               ret_tab_reg, ret_tab_next;
    logic               scrolled_reg, scrolled_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                scr_ok_reg, scr_ok_next;
    logic [SIW-1:0]      sidx_reg, sidx_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [CADDR_W-1:0]  addr_reg, addr_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic [CURSOR_W-1:0] rsp_cursor_reg, rsp_cursor_next;
    logic [CELL_W-1:0]   rsp_cell_reg, rsp_cell_next;
    logic                rsp_scr_reg, rsp_scr_next;

    // Per-screen cursor, its column, its tab phase and the tab phase of its
    // row start, so that no modulo is ever taken of the cursor.
    logic [OW-1:0] cur_reg [SCREENS];
    logic [CW-1:0] col_reg [SCREENS];
    logic [TW-1:0] tph_reg [SCREENS];
    logic [TW-1:0] rph_reg [SCREENS];

    logic          cur_we;
    logic [OW-1:0] cur_next;
    logic [CW-1:0] col_next;
    logic [TW-1:0] tph_next;
    logic [TW-1:0] rph_next;

    logic [OW-1:0] cur_sel;
    logic [CW-1:0] col_sel;
    logic [TW-1:0] tph_sel;
    logic [TW-1:0] rph_sel;

    logic [OW-1:0] row_start;
    logic          at_last_cell;
    logic          row_wrap;
    logic [TW:0]   rph_sum;
    logic [TW-1:0] rph_plus;
    logic [TW-1:0] rph_minus;
    logic [OW-1:0] bs_cur;
    logic [31:0]   addr_w;
    logic          addr_ok;
    logic [31:0]   cur_w;
    logic [4:0]    req_sx;

    logic          scroll_go;
    logic          adv_go;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tmcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TOTAL)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_sel = cur_reg[sidx_reg];
    assign col_sel = col_reg[sidx_reg];
    assign tph_sel = tph_reg[sidx_reg];
    assign rph_sel = rph_reg[sidx_reg];

    assign row_start    = cur_sel - OW'(col_sel);
    assign at_last_cell = (cur_sel == OW'(CELLS - 1));
    assign row_wrap     = (col_sel == CW'(COLUMNS - 1));
    assign bs_cur       = (cur_sel == '0) ? cur_sel : cur_sel - OW'(1);

    // Tab phase of the next or previous row start, kept below TAB_WIDTH.
    assign rph_sum  = {1'b0, rph_sel} + (TW+1)'(CMT);
    assign rph_plus = (rph_sum >= (TW+1)'(TAB_WIDTH))
                    ? TW'(rph_sum - (TW+1)'(TAB_WIDTH)) : rph_sum[TW-1:0];
    assign rph_minus = (rph_sel >= TW'(CMT))
                     ? rph_sel - TW'(CMT)
                     : TW'({1'b0, rph_sel} + (TW+1)'(TAB_WIDTH) - (TW+1)'(CMT));

    assign addr_w  = 32'(addr_reg);
    assign addr_ok = (addr_w < 32'(CELLS));
    assign cur_w   = 32'(cur_sel);
    assign req_sx  = 5'(req.screen_index);

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.cursor_position = rsp_cursor_reg;
    assign rsp.cell_value      = rsp_cell_reg;
    assign rsp.scrolled        = rsp_scr_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        tab_next        = tab_reg;
        ret_tab_next    = ret_tab_reg;
        scrolled_next   = scrolled_reg;
        mode_next       = mode_reg;
        scr_ok_next     = scr_ok_reg;
        sidx_next       = sidx_reg;
        byte_next       = byte_reg;
        addr_next       = addr_reg;
        base_next       = base_reg;
        cell_next       = cell_reg;
        rsp_cursor_next = rsp_cursor_reg;
        rsp_cell_next   = rsp_cell_reg;
        rsp_scr_next    = rsp_scr_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;

        cur_we    = 1'b0;
        cur_next  = cur_sel;
        col_next  = col_sel;
        tph_next  = tph_sel;
        rph_next  = rph_sel;
        scroll_go = 1'b0;
        adv_go    = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = base_reg + AW'(cur_sel);
        ram_wdata = BLANK_CELL;
        ram_raddr = base_reg + AW'(addr_w[OW-1:0]);

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next     = req.mode;
                    byte_next     = req.data_byte;
                    addr_next     = req.cell_address;
                    scr_ok_next   = (32'(req.screen_index) < 32'(SCREENS));
                    sidx_next     = req_sx[SIW-1:0];
                    base_next     = AW'(32'(req.screen_index) * CELLS);
                    scrolled_next = 1'b0;
                    cell_next     = '0;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                if (!scr_ok_reg)
                begin
                    state_next = S_DONE;
                end
                else if (mode_reg == MODE_READ)
                begin
                    if (addr_ok)
                    begin
                        state_next = S_RDWAIT;
                    end
                end
                else
                begin
                    case (byte_reg)
                        CH_CR:
                        begin
                            cur_we   = 1'b1;
                            cur_next = row_start;
                            col_next = '0;
                            tph_next = rph_sel;
                        end
                        CH_LF:
                        begin
                            if (row_start == OW'(LAST_ROW))
                            begin
                                scroll_go    = 1'b1;
                                ret_tab_next = 1'b0;
                            end
                            else
                            begin
                                cur_we   = 1'b1;
                                cur_next = row_start + OW'(COLUMNS);
                                col_next = '0;
                                rph_next = rph_plus;
                                tph_next = rph_plus;
                            end
                        end
                        CH_BS:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = base_reg + AW'(bs_cur);
                            if (cur_sel != '0)
                            begin
                                cur_we   = 1'b1;
                                cur_next = bs_cur;
                                if (col_sel == '0)
                                begin
                                    col_next = CW'(COLUMNS - 1);
                                    rph_next = rph_minus;
                                end
                                else
                                begin
                                    col_next = col_sel - CW'(1);
                                end
                                tph_next = (tph_sel == '0) ? TW'(TAB_WIDTH - 1)
                                                           : tph_sel - TW'(1);
                            end
                        end
                        CH_TAB:
                        begin
                            tab_next   = TLW'(TAB_WIDTH) - TLW'(tph_sel);
                            state_next = S_TAB;
                        end
                        default:
                        begin
                            if (byte_reg inside {[CH_SPACE:CH_TILDE]})
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = TEXT_ATTR | CELL_W'(byte_reg);
                                if (at_last_cell)
                                begin
                                    scroll_go    = 1'b1;
                                    ret_tab_next = 1'b0;
                                end
                                else
                                begin
                                    adv_go = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end

            S_RDWAIT:
            begin
                cell_next  = ram_rdata;
                state_next = S_DONE;
            end

            S_TAB:
            begin
                if (tab_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = TEXT_ATTR | CELL_W'(CH_SPACE);
                    tab_next  = tab_reg - TLW'(1);
                    if (at_last_cell)
                    begin
                        scroll_go    = 1'b1;
                        ret_tab_next = 1'b1;
                    end
                    else
                    begin
                        adv_go = 1'b1;
                    end
                end
            end

            S_SCROLL:
            begin
                // Read one row ahead and write back the cell read last cycle.
                ram_raddr = base_reg + AW'(cnt_reg) + AW'(COLUMNS);
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = base_reg + AW'(cnt_reg - OW'(1));
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == OW'(LAST_ROW))
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + OW'(1);
                end
            end

            S_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = base_reg + AW'(cnt_reg);
                if (cnt_reg == OW'(CELLS - 1))
                begin
                    state_next = ret_tab_reg ? S_TAB : S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + OW'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_cursor_next = scr_ok_reg ? cur_w[CURSOR_W-1:0] : '0;
                    rsp_cell_next   = cell_reg;
                    rsp_scr_next    = scrolled_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv_go)
        begin
            cur_we   = 1'b1;
            cur_next = cur_sel + OW'(1);
            col_next = row_wrap ? '0 : col_sel + CW'(1);
            rph_next = row_wrap ? rph_plus : rph_sel;
            tph_next = (tph_sel == TW'(TAB_WIDTH - 1)) ? '0 : tph_sel + TW'(1);
        end

        // The cursor lands on the bottom row start as soon as a scroll begins.
        if (scroll_go)
        begin
            cur_we        = 1'b1;
            cur_next      = OW'(LAST_ROW);
            col_next      = '0;
            tph_next      = TW'(LAST_PH);
            rph_next      = TW'(LAST_PH);
            scrolled_next = 1'b1;
            cnt_next      = '0;
            state_next    = S_SCROLL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            tab_reg       <= '0;
            ret_tab_reg   <= 1'b0;
            scrolled_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            scr_ok_reg    <= 1'b0;
            sidx_reg      <= '0;
            for (int i = 0; i < SCREENS; i++)
            begin
                cur_reg[i] <= '0;
                col_reg[i] <= '0;
                tph_reg[i] <= '0;
                rph_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            tab_reg       <= tab_next;
            ret_tab_reg   <= ret_tab_next;
            scrolled_reg  <= scrolled_next;
            rsp_valid_reg <= rsp_valid_next;
            scr_ok_reg    <= scr_ok_next;
            sidx_reg      <= sidx_next;
            if (cur_we)
            begin
                cur_reg[sidx_reg] <= cur_next;
                col_reg[sidx_reg] <= col_next;
                tph_reg[sidx_reg] <= tph_next;
                rph_reg[sidx_reg] <= rph_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        byte_reg       <= byte_next;
        addr_reg       <= addr_next;
        base_reg       <= base_next;
        cell_reg       <= cell_next;
        rsp_cursor_reg <= rsp_cursor_next;
        rsp_cell_reg   <= rsp_cell_next;
        rsp_scr_reg    <= rsp_scr_next;
    end

    // Outside the clearing pass every cell write stays inside the addressed screen.
    a_write_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != S_CLEAR) |->
            (ram_waddr >= base_reg && 32'(ram_waddr) < 32'(base_reg) + 32'(CELLS)))
        else $error("cell write outside the addressed screen");

    // A cursor update never leaves the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_we |-> (32'(cur_next) < 32'(CELLS) && 32'(col_next) < 32'(COLUMNS)))
        else $error("cursor update out of range");

    // Only a write on a valid screen can walk the cells for a scroll.
    a_scroll_write_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL || state_reg == S_BLANK) |->
            (scrolled_reg && scr_ok_reg && mode_reg == MODE_WRITE))
        else $error("scroll walk without a write transaction");

endmodule

/* src/tmcw_ram.sv */
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmcw_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
